// ===== src/aqpe_pkg.sv =====
// aqpe_pkg: shared widths, constants and codes of the quadric parameter estimator
// used by the top level, the shared multiplier and the port checker; no dependencies
package aqpe_pkg;

    localparam int EST_FRAC_BITS = 20;

    localparam int CRD_W      = 16;
    localparam int EST_W      = 24;
    localparam int ERR_W      = 31;
    localparam int PHI_W      = 32;
    localparam int ACC_W      = 58;
    localparam int P_W        = 47;
    localparam int STP_W      = 41;
    localparam int GAIN_W     = 16;
    localparam int DZ_W       = 20;
    localparam int LIM_W      = 23;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int N_TERMS    = 6;
    localparam int N_DIAG     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DAT_W  = 23;
    localparam int IN_DATA_W  = 6 * CRD_W;
    localparam int OUT_DATA_W = ((N_TERMS * EST_W + ERR_W + 7) / 8) * 8;

    localparam logic signed [EST_W-1:0] EST_MAXV = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic signed [EST_W-1:0] EST_MINV = {1'b1, {(EST_W-1){1'b0}}};
    localparam logic signed [ERR_W-1:0] ERR_MAXV = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MINV = {1'b1, {(ERR_W-1){1'b0}}};

    localparam longint ONE_RAW = 64'sd1 <<< EST_FRAC_BITS;
    localparam logic signed [EST_W-1:0] EST_ONE =
        (ONE_RAW > longint'(EST_MAXV)) ? EST_MAXV : EST_W'(ONE_RAW);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_GAIN  = 2'd0,
        REG_DEADZONE   = 2'd1,
        REG_DIAG_LIMIT = 2'd2
    } t_reg_idx;

endpackage

// ===== src/aqpe_mul.sv =====
// aqpe_mul: shared signed multiplier with registered product
// depends on aqpe_pkg for operand and product widths
module aqpe_mul import aqpe_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end

endmodule

// ===== src/adaptive_quadric_param_estimator.sv =====
// adaptive_quadric_param_estimator: gradient adaptive law with projection, six-term estimate
// a new item is accepted only in idle, after the previous result has been loaded into the output register
// one 32x32 multiplier is used 36 times per item under a sequencer
// (12 regressor products, 6 dot products, 3 per term for the update)
// reset (synchronous, active low): idle, output empty, registers at defaults, estimate 1,0,1,0,0,0
// depends on aqpe_pkg and aqpe_mul
module adaptive_quadric_param_estimator import aqpe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // restart
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // est_xx, est_yy, est_zz, est_xy, est_yz, est_xz, pred_error, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PHI  = 6'b000010,
        ST_DOT  = 6'b000100,
        ST_ERR  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    localparam logic [3:0] PHI_LAST  = 4'(2 * N_TERMS);
    localparam logic [3:0] DOT_LAST  = 4'(N_TERMS);
    localparam logic [2:0] TERM_LAST = 3'(N_TERMS - 1);

    localparam logic [2:0] SL_ISSUE_E  = 3'd0;
    localparam logic [2:0] SL_TAKE_E   = 3'd1;
    localparam logic [2:0] SL_ISSUE_HI = 3'd2;
    localparam logic [2:0] SL_TAKE_HI  = 3'd3;
    localparam logic [2:0] SL_TAKE_LO  = 3'd4;
    localparam logic [2:0] SL_WRITE    = 3'd5;

    localparam logic signed [ACC_W:0]    ERR_HALF = (ACC_W+1)'(1) <<< 23;
    localparam logic signed [PROD_W-1:0] P_RND    = PROD_W'(1) <<< 15;
    localparam logic signed [PROD_W-1:0] S_RND    = PROD_W'(1) <<< 23;

    t_state r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_term, n_term;
    logic [2:0] r_slot, n_slot;
    logic       r_ovalid, n_ovalid;

    logic [GAIN_W-1:0] r_gain;
    logic [DZ_W-1:0]   r_dz;
    logic [LIM_W-1:0]  r_lim;

    logic signed [CRD_W-1:0]  r_fx, r_fy, r_fz, r_sx, r_sy, r_sz;
    logic signed [EST_W-1:0]  r_est [N_TERMS];
    logic signed [PHI_W-1:0]  r_phi [N_TERMS];
    logic signed [PHI_W-1:0]  r_tmp;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ERR_W-1:0]  r_err;
    logic [P_W-1:0]           r_p;
    logic signed [STP_W-1:0]  r_sh;
    logic signed [STP_W-1:0]  r_stp;
    logic [OUT_DATA_W-1:0]    r_odata;

    logic                      in_acc;
    logic                      out_load;
    logic [2:0]                raw_idx, sel_idx, phi_wr_idx;
    logic signed [EST_W-1:0]   est_rd;
    logic signed [PHI_W-1:0]   phi_rd;
    logic signed [CRD_W-1:0]   crd_a, crd_b;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W:0]     err_sum;
    logic signed [ACC_W-24:0]  err_sh;
    logic signed [ERR_W-1:0]   err_sat;
    logic signed [PROD_W-1:0]  p_full, lo_full;
    logic [17:0]               lo_rnd;
    logic signed [STP_W-1:0]   stp_eff;
    logic signed [STP_W:0]     upd_sum;
    logic signed [EST_W-1:0]   nv_sat, nv_new, lim_s;
    logic [EST_W-1:0]          nv_abs;
    logic                      is_diag;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_DONE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign o_cfg_ready   = 1'b1;

    // one read port on the estimate and regressor registers
    always_comb begin
        raw_idx = (r_state == ST_DOT) ? r_cnt[2:0] : r_term;
        sel_idx = (raw_idx < 3'(N_TERMS)) ? raw_idx : '0;
        est_rd  = r_est[sel_idx];
        phi_rd  = r_phi[sel_idx];
    end

    assign phi_wr_idx = 3'(r_cnt[3:1] - 3'd1);

    always_comb begin
        crd_a = '0;
        crd_b = '0;
        unique case (r_cnt)
            4'd0:    begin crd_a = r_fx; crd_b = r_fx; end
            4'd1:    begin crd_a = r_sx; crd_b = r_sx; end
            4'd2:    begin crd_a = r_fy; crd_b = r_fy; end
            4'd3:    begin crd_a = r_sy; crd_b = r_sy; end
            4'd4:    begin crd_a = r_fz; crd_b = r_fz; end
            4'd5:    begin crd_a = r_sz; crd_b = r_sz; end
            4'd6:    begin crd_a = r_fx; crd_b = r_fy; end
            4'd7:    begin crd_a = r_sx; crd_b = r_sy; end
            4'd8:    begin crd_a = r_fy; crd_b = r_fz; end
            4'd9:    begin crd_a = r_sy; crd_b = r_sz; end
            4'd10:   begin crd_a = r_fx; crd_b = r_fz; end
            4'd11:   begin crd_a = r_sx; crd_b = r_sz; end
            default: begin crd_a = '0;   crd_b = '0;   end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_PHI: begin
                mul_a = MUL_W'(crd_a);
                mul_b = MUL_W'(crd_b);
            end
            ST_DOT: begin
                mul_a = MUL_W'(est_rd);
                mul_b = MUL_W'(phi_rd);
            end
            ST_UPD: begin
                unique case (r_slot)
                    SL_ISSUE_E: begin
                        mul_a = MUL_W'(r_err);
                        mul_b = MUL_W'(phi_rd);
                    end
                    SL_ISSUE_HI: begin
                        mul_a = MUL_W'($signed(r_p[P_W-1:24]));
                        mul_b = MUL_W'($signed({1'b0, r_gain}));
                    end
                    SL_TAKE_HI: begin
                        mul_a = MUL_W'($signed({1'b0, r_p[23:0]}));
                        mul_b = MUL_W'($signed({1'b0, r_gain}));
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    aqpe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // error: round half up by 24 bits, then saturate
    always_comb begin
        err_sum = ERR_HALF - (ACC_W+1)'(r_acc);
        err_sh  = err_sum[ACC_W:24];
        if (err_sh > (ACC_W-23)'(ERR_MAXV)) begin
            err_sat = ERR_MAXV;
        end else if (err_sh < (ACC_W-23)'(ERR_MINV)) begin
            err_sat = ERR_MINV;
        end else begin
            err_sat = err_sh[ERR_W-1:0];
        end
    end

    assign p_full  = prod + P_RND;
    assign lo_full = prod + S_RND;
    assign lo_rnd  = lo_full[41:24];

    // term update with projection, clamp and deadzone
    always_comb begin
        is_diag = (r_term < 3'(N_DIAG));
        stp_eff = (is_diag && est_rd < 0 && r_stp < 0) ? '0 : r_stp;
        upd_sum = (STP_W+1)'(est_rd) + (STP_W+1)'(stp_eff);
        if (upd_sum > (STP_W+1)'(EST_MAXV)) begin
            nv_sat = EST_MAXV;
        end else if (upd_sum < (STP_W+1)'(EST_MINV)) begin
            nv_sat = EST_MINV;
        end else begin
            nv_sat = upd_sum[EST_W-1:0];
        end
        lim_s  = $signed({1'b0, r_lim});
        nv_abs = nv_sat[EST_W-1] ? EST_W'(-nv_sat) : EST_W'(nv_sat);
        if (is_diag) begin
            if (nv_sat < 0) begin
                nv_new = '0;
            end else if (nv_sat > lim_s) begin
                nv_new = lim_s;
            end else begin
                nv_new = nv_sat;
            end
        end else begin
            nv_new = (nv_abs < EST_W'(r_dz)) ? '0 : nv_sat;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_term  = r_term;
        n_slot  = r_slot;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_PHI;
                    n_cnt   = '0;
                end
            end
            ST_PHI: begin
                if (r_cnt == PHI_LAST) begin
                    n_state = ST_DOT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_DOT: begin
                if (r_cnt == DOT_LAST) begin
                    n_state = ST_ERR;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_ERR: begin
                n_state = ST_UPD;
                n_term  = '0;
                n_slot  = SL_ISSUE_E;
            end
            ST_UPD: begin
                if (r_slot == SL_WRITE) begin
                    n_slot = SL_ISSUE_E;
                    if (r_term == TERM_LAST) begin
                        n_state = ST_DONE;
                    end else begin
                        n_term = r_term + 3'd1;
                    end
                end else begin
                    n_slot = r_slot + 3'd1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (out_load) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_term   <= '0;
            r_slot   <= SL_ISSUE_E;
            r_ovalid <= 1'b0;
            r_gain   <= GAIN_W'(328);
            r_dz     <= DZ_W'(105);
            r_lim    <= LIM_W'(1048576);
            r_est[0] <= EST_ONE;
            r_est[1] <= '0;
            r_est[2] <= EST_ONE;
            r_est[3] <= '0;
            r_est[4] <= '0;
            r_est[5] <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_term   <= n_term;
            r_slot   <= n_slot;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_STEP_GAIN:  r_gain <= i_cfg_data[GAIN_W-1:0];
                    REG_DEADZONE:   r_dz   <= i_cfg_data[DZ_W-1:0];
                    REG_DIAG_LIMIT: r_lim  <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc && s_axis_tuser) begin
                r_est[0] <= EST_ONE;
                r_est[1] <= '0;
                r_est[2] <= EST_ONE;
                r_est[3] <= '0;
                r_est[4] <= '0;
                r_est[5] <= '0;
            end else if (r_state == ST_UPD && r_slot == SL_WRITE) begin
                r_est[sel_idx] <= nv_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fx <= s_axis_tdata[CRD_W-1:0];
            r_fy <= s_axis_tdata[2*CRD_W-1:CRD_W];
            r_fz <= s_axis_tdata[3*CRD_W-1:2*CRD_W];
            r_sx <= s_axis_tdata[4*CRD_W-1:3*CRD_W];
            r_sy <= s_axis_tdata[5*CRD_W-1:4*CRD_W];
            r_sz <= s_axis_tdata[6*CRD_W-1:5*CRD_W];
        end
        if (r_state == ST_PHI && r_cnt != 4'd0) begin
            if (r_cnt[0]) begin
                r_tmp <= prod[PHI_W-1:0];
            end else begin
                r_phi[phi_wr_idx] <= r_tmp - $signed(prod[PHI_W-1:0]);
            end
        end
        if (r_state == ST_DOT) begin
            if (r_cnt == 4'd1) begin
                r_acc <= prod[ACC_W-1:0];
            end else if (r_cnt != 4'd0) begin
                r_acc <= r_acc + $signed(prod[ACC_W-1:0]);
            end
        end
        if (r_state == ST_ERR) begin
            r_err <= err_sat;
        end
        if (r_state == ST_UPD) begin
            if (r_slot == SL_TAKE_E) begin
                r_p <= p_full[P_W+15:16];
            end
            if (r_slot == SL_TAKE_HI) begin
                r_sh <= prod[STP_W-1:0];
            end
            if (r_slot == SL_TAKE_LO) begin
                r_stp <= r_sh + STP_W'($signed({1'b0, lo_rnd}));
            end
        end
        if (out_load) begin
            r_odata <= {1'b0, r_err, r_est[5], r_est[4], r_est[3],
                        r_est[2], r_est[1], r_est[0]};
        end
    end

endmodule

// ===== src/aqpe_chk.sv =====
// aqpe_chk: port-level checks on the quadric parameter estimator, bound to the top level
// depends on aqpe_pkg and adaptive_quadric_param_estimator
module aqpe_chk import aqpe_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DAT_W-1:0]  i_cfg_data
);

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

    // an accepted item keeps the input side closed while it is worked on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while an item is in work");

    // a new result only appears at the end of an item's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an item in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind adaptive_quadric_param_estimator aqpe_chk u_aqpe_chk (.*);
